@@ hdl/kcle_pkg.sv @@
// ----------------------------------------------------------------------------
// kcle_pkg
// Shared types and constants for the keyed circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kcle_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_UPDATE  = 3'd4,
    OP_LOOKUP  = 3'd5,
    OP_DUMP    = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

`default_nettype wire

@@ hdl/kcle_ram.sv @@
// ----------------------------------------------------------------------------
// kcle_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kcle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/keyed_circular_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// keyed_circular_list_engine_top
// Circular singly linked list of unique-key entries held in a node pool.
// ----------------------------------------------------------------------------
// The list lives in three RAMs (keys, data, next links) that share one read
// address. A search by key walks the list one entry per cycle; insert after
// an anchor walks twice. An insert then writes the entry and, on a non-empty
// list, relinks its predecessor; a delete relinks unless the list empties. A
// dump streams head to tail, one entry per cycle while output is free. A new
// request is taken while the prior result still sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_circular_list_engine_top #(
  parameter int unsigned CAPACITY = kcle_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // op[2:0], key[34:3], data[66:35], anchor_key[98:67]
  input  wire logic [kcle_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // status[2:0], out_key[34:3], out_data[66:35]
  output logic      [kcle_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                    out_tlast
);

  import kcle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FA   = 8'b0000_0010,
    S_FK   = 8'b0000_0100,
    S_INS  = 8'b0000_1000,
    S_INS2 = 8'b0001_0000,
    S_DEL  = 8'b0010_0000,
    S_DUMP = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;
  op_t op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt, anc_r, anc_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt, prev_r, prev_nxt;
  logic [AW-1:0] a_r, a_nxt, anext_r, anext_nxt;
  logic [AW-1:0] p_r, p_nxt, pred_r, pred_nxt, plink_r, plink_nxt, s_r, s_nxt;
  status_t res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;

  logic              out_tvalid_r;
  status_t           out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic              out_load, out_free;
  status_t           ld_status;
  logic [KEY_W-1:0]  ld_key;
  logic [DATA_W-1:0] ld_data;
  logic              ld_last;

  logic [AW-1:0]     rd_addr;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     lnk_q;
  logic              kv_we, val_we, lnk_we;
  logic [AW-1:0]     kv_waddr, val_waddr, lnk_waddr, lnk_wdata;
  logic [DATA_W-1:0] val_wdata;

  logic [AW-1:0]     free_idx;
  logic [KEY_W-1:0]  tgt;
  logic              hit, wdone, ins_op;

  kcle_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(key_r),
    .raddr(rd_addr), .rdata_r(key_q)
  );

  kcle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(rd_addr), .rdata_r(val_q)
  );

  kcle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(rd_addr), .rdata_r(lnk_q)
  );

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  assign tgt      = (st_r == S_FA) ? anc_r : key_r;
  assign hit      = (key_q == tgt);
  assign wdone    = (n_r == cnt_r);
  assign ins_op   = (op_r == OP_APPEND) || (op_r == OP_PREPEND) || (op_r == OP_INSERT);
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;  op_nxt = op_r;  key_nxt = key_r;  anc_nxt = anc_r;
    data_nxt = data_r;  head_nxt = head_r;  tail_nxt = tail_r;
    cnt_nxt = cnt_r;  n_nxt = n_r;  used_nxt = used_r;
    ptr_nxt = ptr_r;  prev_nxt = prev_r;  a_nxt = a_r;  anext_nxt = anext_r;
    p_nxt = p_r;  pred_nxt = pred_r;  plink_nxt = plink_r;  s_nxt = s_r;
    res_status_nxt = res_status_r;  res_key_nxt = res_key_r;
    res_data_nxt = res_data_r;
    rd_addr = ptr_r;
    kv_we = 1'b0;  kv_waddr = free_idx;
    val_we = 1'b0;  val_waddr = free_idx;  val_wdata = data_r;
    lnk_we = 1'b0;  lnk_waddr = free_idx;  lnk_wdata = head_r;
    out_load = 1'b0;  ld_status = res_status_r;  ld_key = res_key_r;
    ld_data = res_data_r;  ld_last = 1'b1;

    case (st_r)
      S_IDLE: begin
        rd_addr = head_r;
        if (in_tvalid) begin
          op_nxt   = op_t'(in_tdata[2:0]);
          key_nxt  = in_tdata[34:3];
          data_nxt = in_tdata[66:35];
          anc_nxt  = in_tdata[98:67];
          ptr_nxt  = head_r;
          prev_nxt = tail_r;
          n_nxt    = '0;
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_data_nxt   = '0;
          case (op_t'(in_tdata[2:0]))
            OP_APPEND, OP_PREPEND, OP_DELETE, OP_UPDATE, OP_LOOKUP: st_nxt = S_FK;
            OP_INSERT: st_nxt = S_FA;
            OP_DUMP: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
                st_nxt = S_RESP;
              end else begin
                st_nxt = S_DUMP;
              end
            end
            default: st_nxt = S_RESP;
          endcase
        end
      end

      S_FA: begin
        if (wdone) begin
          res_status_nxt = ST_NOTFOUND;
          st_nxt = S_RESP;
        end else if (hit) begin
          // anchor found: restart the walk for the new key
          a_nxt     = ptr_r;
          anext_nxt = lnk_q;
          rd_addr   = head_r;
          ptr_nxt   = head_r;
          prev_nxt  = tail_r;
          n_nxt     = '0;
          st_nxt    = S_FK;
        end else begin
          rd_addr  = lnk_q;
          ptr_nxt  = lnk_q;
          prev_nxt = ptr_r;
          n_nxt    = n_r + CW'(1);
        end
      end

      S_FK: begin
        if (wdone) begin
          if (ins_op) begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              st_nxt = S_RESP;
            end else begin
              st_nxt = S_INS;
            end
          end else begin
            res_status_nxt = ST_NOTFOUND;
            st_nxt = S_RESP;
          end
        end else if (hit) begin
          case (op_r)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
              res_status_nxt = ST_DUP;
              st_nxt = S_RESP;
            end
            OP_DELETE: begin
              p_nxt     = ptr_r;
              pred_nxt  = prev_r;
              plink_nxt = lnk_q;
              st_nxt    = S_DEL;
            end
            OP_UPDATE: begin
              val_we    = 1'b1;
              val_waddr = ptr_r;
              st_nxt    = S_RESP;
            end
            OP_LOOKUP: begin
              res_key_nxt  = key_q;
              res_data_nxt = val_q;
              st_nxt       = S_RESP;
            end
            default: st_nxt = S_RESP;
          endcase
        end else begin
          rd_addr  = lnk_q;
          ptr_nxt  = lnk_q;
          prev_nxt = ptr_r;
          n_nxt    = n_r + CW'(1);
        end
      end

      S_INS: begin
        s_nxt  = free_idx;
        kv_we  = 1'b1;
        val_we = 1'b1;
        lnk_we = 1'b1;
        used_nxt[free_idx] = 1'b1;
        // count moves with the used flag so both always agree
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          lnk_wdata = free_idx;
          head_nxt  = free_idx;
          tail_nxt  = free_idx;
          st_nxt    = S_RESP;
        end else begin
          lnk_wdata = (op_r == OP_INSERT) ? anext_r : head_r;
          st_nxt    = S_INS2;
        end
      end

      S_INS2: begin
        lnk_we    = 1'b1;
        lnk_waddr = (op_r == OP_INSERT) ? a_r : tail_r;
        lnk_wdata = s_r;
        if (op_r == OP_APPEND) begin
          tail_nxt = s_r;
        end else if (op_r == OP_PREPEND) begin
          head_nxt = s_r;
        end else if (a_r == tail_r) begin
          tail_nxt = s_r;
        end
        st_nxt  = S_RESP;
      end

      S_DEL: begin
        if (cnt_r <= CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          // predecessor of the head is the tail, so one link write covers both
          lnk_we    = 1'b1;
          lnk_waddr = pred_r;
          lnk_wdata = plink_r;
          if (p_r == head_r) head_nxt = plink_r;
          if (p_r == tail_r) tail_nxt = pred_r;
        end
        used_nxt[p_r] = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
        st_nxt  = S_RESP;
      end

      S_DUMP: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_OK;
          ld_key    = key_q;
          ld_data   = val_q;
          ld_last   = ((n_r + CW'(1)) == cnt_r);
          if (ld_last) begin
            st_nxt = S_IDLE;
          end else begin
            rd_addr = lnk_q;
            ptr_nxt = lnk_q;
            n_nxt   = n_r + CW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      used_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  key_r <= key_nxt;  anc_r <= anc_nxt;  data_r <= data_nxt;
    n_r <= n_nxt;  ptr_r <= ptr_nxt;  prev_r <= prev_nxt;
    a_r <= a_nxt;  anext_r <= anext_nxt;
    p_r <= p_nxt;  pred_r <= pred_nxt;  plink_r <= plink_nxt;  s_r <= s_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_data_r   <= res_data_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key;
      out_data_r   <= ld_data;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_data_r, out_key_r, out_status_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(cnt_r))
    else $error("entry count disagrees with used slots");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_INS |-> cnt_r < CW'(CAPACITY))
    else $error("insert into full pool");

  a_del_used: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DEL |-> used_r[p_r])
    else $error("delete of a free slot");

endmodule

`default_nettype wire

@@ dv/keyed_circular_list_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_circular_list_engine_top_tb
// Drives list requests (append, prepend, insert after, delete, update,
// lookup, dump) with random gaps and output stalls, keeps its own copy of
// the linked list and checks every returned entry and status in order.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_circular_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcle_pkg::*;

  localparam int unsigned POOL = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0]  anchor_key;
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic [OP_W-1:0]   op;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    rkey;
    logic [DATA_W-1:0]   rdata;
    logic                rlast;
  } entry_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  keyed_circular_list_engine_top #(.CAPACITY(POOL)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // list shadow
  logic [KEY_W-1:0]  list_keys [POOL];
  logic [DATA_W-1:0] list_vals [POOL];
  int unsigned       list_next [POOL];
  bit                list_used [POOL];
  int unsigned       head_slot, tail_slot, list_len;

  request_t    pending_reqs[$];
  entry_resp_t expected_resps[$];
  int          error_count = 0;
  bit          stim_done = 1'b0;
  bit          in_fired = 1'b0;
  bit          out_fired = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic int unsigned find_slot(input logic [KEY_W-1:0] k);
    int unsigned p;
    p = head_slot;
    for (int unsigned n = 0; n < list_len; n++) begin
      if (list_keys[p] == k) return p;
      p = list_next[p];
    end
    return POOL;
  endfunction

  function automatic void push_resp(input status_t st, input logic [KEY_W-1:0] k,
                                    input logic [DATA_W-1:0] d, input logic l);
    entry_resp_t r;
    r.status = st;
    r.rkey = k;
    r.rdata = d;
    r.rlast = l;
    expected_resps.push_back(r);
  endfunction

  function automatic void apply_request(input request_t rq);
    int unsigned a, s, p, pred;
    case (rq.op)
      OP_APPEND, OP_PREPEND, OP_INSERT: begin
        a = POOL;
        if (rq.op == OP_INSERT) begin
          a = find_slot(rq.anchor_key);
          if (a >= POOL) begin
            push_resp(ST_NOTFOUND, '0, '0, 1'b1);
            return;
          end
        end
        if (find_slot(rq.key) < POOL) begin
          push_resp(ST_DUP, '0, '0, 1'b1);
          return;
        end
        s = POOL;
        for (int unsigned i = 0; i < POOL; i++)
          if (!list_used[i] && s == POOL) s = i;
        if (s >= POOL) begin
          push_resp(ST_FULL, '0, '0, 1'b1);
          return;
        end
        list_used[s] = 1'b1;
        list_keys[s] = rq.key;
        list_vals[s] = rq.data;
        if (list_len == 0) begin
          head_slot = s;
          tail_slot = s;
          list_next[s] = s;
        end else if (rq.op == OP_APPEND) begin
          list_next[tail_slot] = s;
          list_next[s] = head_slot;
          tail_slot = s;
        end else if (rq.op == OP_PREPEND) begin
          list_next[s] = head_slot;
          list_next[tail_slot] = s;
          head_slot = s;
        end else begin
          list_next[s] = list_next[a];
          list_next[a] = s;
          if (a == tail_slot) tail_slot = s;
        end
        list_len++;
        push_resp(ST_OK, '0, '0, 1'b1);
      end
      OP_DELETE: begin
        p = find_slot(rq.key);
        if (p >= POOL) begin
          push_resp(ST_NOTFOUND, '0, '0, 1'b1);
          return;
        end
        if (list_len <= 1) begin
          head_slot = 0;
          tail_slot = 0;
        end else if (p == head_slot) begin
          head_slot = list_next[p];
          list_next[tail_slot] = head_slot;
        end else begin
          pred = head_slot;
          for (int unsigned n = 0; n < POOL && list_next[pred] != p; n++)
            pred = list_next[pred];
          list_next[pred] = list_next[p];
          if (p == tail_slot) tail_slot = pred;
        end
        list_used[p] = 1'b0;
        list_len--;
        push_resp(ST_OK, '0, '0, 1'b1);
      end
      OP_UPDATE: begin
        p = find_slot(rq.key);
        if (p >= POOL) begin
          push_resp(ST_NOTFOUND, '0, '0, 1'b1);
          return;
        end
        list_vals[p] = rq.data;
        push_resp(ST_OK, '0, '0, 1'b1);
      end
      OP_LOOKUP: begin
        p = find_slot(rq.key);
        if (p >= POOL) push_resp(ST_NOTFOUND, '0, '0, 1'b1);
        else push_resp(ST_OK, list_keys[p], list_vals[p], 1'b1);
      end
      OP_DUMP: begin
        if (list_len == 0) begin
          push_resp(ST_EMPTY, '0, '0, 1'b1);
          return;
        end
        p = head_slot;
        for (int unsigned n = 0; n < list_len; n++) begin
          push_resp(ST_OK, list_keys[p], list_vals[p], n + 1 == list_len);
          p = list_next[p];
        end
      end
      default: push_resp(ST_OK, '0, '0, 1'b1);
    endcase
  endfunction

  // driver
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      // advance past the request taken at the last rising edge
      if (in_fired) begin
        pending_reqs.pop_front();
        in_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= IN_TDATA_W'(pending_reqs[0]);
      end else begin
        in_tvalid <= 1'b0;
      end
      if (out_fired) out_gap = $urandom_range(0, 9);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    entry_resp_t got, want;
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (rst_n) begin
      in_fired = in_tvalid && in_tready;
      out_fired = out_tvalid && out_tready;
      if (in_fired)
        apply_request(request_t'(in_tdata[$bits(request_t)-1:0]));
      if (out_fired) begin
        got.status = out_tdata[2:0];
        got.rkey = out_tdata[34:3];
        got.rdata = out_tdata[66:35];
        got.rlast = out_tlast;
        if (expected_resps.size() == 0) begin
          report($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = expected_resps.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d want %0d", got.status, want.status));
          if (got.rkey != want.rkey)
            report($sformatf("key %h want %h", got.rkey, want.rkey));
          if (got.rdata != want.rdata)
            report($sformatf("data %h want %h", got.rdata, want.rdata));
          if (got.rlast != want.rlast)
            report($sformatf("last %0b want %0b", got.rlast, want.rlast));
        end
      end
    end
  end

  function automatic request_t make_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                        input logic [DATA_W-1:0] d, input logic [KEY_W-1:0] a);
    request_t r;
    r.op = op;
    r.key = k;
    r.data = d;
    r.anchor_key = a;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    // small key pool so hits, duplicates and a full list all occur
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7fff_ffff - $urandom_range(0, 2);
      2: return $urandom();
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    int unsigned w;
    for (int unsigned i = 0; i < POOL; i++) list_used[i] = 1'b0;
    head_slot = 0;
    tail_slot = 0;
    list_len = 0;

    // directed: empty cases, extremes, ordering of insert checks, full pool
    pending_reqs.push_back(make_req(OP_DUMP, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_DELETE, 5, 0, 0));
    pending_reqs.push_back(make_req(OP_UPDATE, 5, 1, 0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 5, 0, 0));
    pending_reqs.push_back(make_req(OP_INSERT, 1, 1, 9));
    pending_reqs.push_back(make_req(OP_APPEND, 32'h8000_0000, 32'hffff_ffff, 0));
    pending_reqs.push_back(make_req(OP_PREPEND, 32'h7fff_ffff, 32'h0, 0));
    pending_reqs.push_back(make_req(OP_APPEND, 32'h7fff_ffff, 1, 0));
    pending_reqs.push_back(make_req(OP_INSERT, 3, 32'h8000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(OP_INSERT, 3, 3, 32'h1234));
    pending_reqs.push_back(make_req(OP_INSERT, 4, 4, 32'h8000_0000));
    pending_reqs.push_back(make_req(OP_UPDATE, 3, 32'h7fff_ffff, 0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 32'h8000_0000, 0, 0));
    pending_reqs.push_back(make_req(OP_DUMP, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_UNUSED, 0, 0, 0));
    for (int unsigned i = 0; i < POOL - 3; i++)
      pending_reqs.push_back(make_req(OP_APPEND, 100 + i, $urandom(), 0));
    pending_reqs.push_back(make_req(OP_PREPEND, 999, 0, 0));
    pending_reqs.push_back(make_req(OP_INSERT, 3, 0, 100));
    pending_reqs.push_back(make_req(OP_DUMP, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_DELETE, 4, 0, 0));
    pending_reqs.push_back(make_req(OP_DELETE, 32'h7fff_ffff, 0, 0));

    // random: mostly valid ops on a small key set
    for (int unsigned i = 0; i < 420; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40) op = OP_W'(OP_APPEND + $urandom_range(0, 2));
      else if (w < 60) op = OP_DELETE;
      else if (w < 70) op = OP_UPDATE;
      else if (w < 82) op = OP_LOOKUP;
      else if (w < 97) op = OP_DUMP;
      else op = OP_UNUSED;
      pending_reqs.push_back(make_req(op, pick_key(), $urandom(), pick_key()));
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_resps.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
